// File: sv/mac_pkg.sv
// package for the matroid axiom checker
// sizes, state encoding and popcount helper; no dependencies
package mac_pkg;
  localparam int ELEMENTS = 10;
  localparam int MAX_SETS = 1024;
  localparam int TBL_DEPTH = 1 << ELEMENTS;
  localparam int SET_AW = $clog2(MAX_SETS);
  localparam int CNT_W = SET_AW + 1;
  localparam int EW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int PC_W = $clog2(ELEMENTS + 1);

  typedef logic [ELEMENTS-1:0] set_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_EMPTY, ST_HRD_A, ST_HRD_S, ST_HRD_C,
    ST_EX_A, ST_EX_B, ST_EX_E, ST_EX_C, ST_DONE
  } state_t;

  function automatic logic [PC_W-1:0] pop_count(input set_t v);
    logic [PC_W-1:0] s;
    s = '0;
    for (int i = 0; i < ELEMENTS; i++) s = s + PC_W'(v[i]);
    return s;
  endfunction
endpackage

// File: sv/mac_ram.sv
// generic ram with one write port and one read port, registered read
// no dependencies
module mac_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/matroid_axiom_checker_top.sv
// Matroid independence checker. Evaluate walks the sets from a table ram and
// a set-list ram, one access per ram per cycle: first the empty check, then
// each listed set and its submasks, then each set A and each ordered pair
// of sets, and last the table clear; a failed check skips ahead to the clear.
// The verdict then waits in the output register and input stalls until it
// is taken. After reset the input stalls for the table clear.
// Uses mac_pkg and mac_ram.
module matroid_axiom_checker_top
  import mac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_element,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_matroid
);
  state_t st_r, st_nxt;
  set_t cur_r, cur_nxt, sa_r, sa_nxt, sb_r, sb_nxt, sub_r, sub_nxt;
  cnt_t cnt_r, cnt_nxt, ia_r, ia_nxt, ib_r, ib_nxt;
  logic [ELEMENTS:0] clr_r, clr_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic ok_r, ok_nxt, ov_r, ov_nxt, ph_r, ph_nxt, boot_r, boot_nxt;

  logic t_we, t_wd, t_rd, s_we;
  set_t t_wa, t_ra, s_rd;
  logic [SET_AW-1:0] s_ra;

  mac_ram #(.WIDTH(1), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  mac_ram #(.WIDTH(ELEMENTS), .DEPTH(MAX_SETS)) u_list (
    .clk, .we(s_we), .waddr(cnt_r[SET_AW-1:0]), .wdata(cur_r), .raddr(s_ra),
    .rdata(s_rd));

  logic acc, oacc;
  set_t ebit, diff;
  assign acc = in_valid && !in_stall;
  assign oacc = out_valid && !out_stall;
  assign in_stall = (st_r != ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_is_matroid = ok_r;
  assign ebit = set_t'(1) << e_r;
  assign diff = sa_r & ~sb_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc && in_cmd == CMD_EVAL) st_nxt = ST_EMPTY;
      ST_EMPTY: st_nxt = !ph_r ? ST_EMPTY : (!t_rd ? ST_CLEAR
                         : (cnt_r == '0 ? ST_EX_A : ST_HRD_A));
      ST_HRD_A: if (ph_r) st_nxt = ST_HRD_S;
      ST_HRD_S: st_nxt = (sub_r == '0) ? ((ia_r + 1'b1 == cnt_r) ? ST_EX_A : ST_HRD_A)
                         : ST_HRD_C;
      ST_HRD_C: st_nxt = !t_rd ? ST_CLEAR : ST_HRD_S;
      ST_EX_A: st_nxt = (ia_r == cnt_r) ? ST_CLEAR : (ph_r ? ST_EX_B : ST_EX_A);
      ST_EX_B: if (ph_r) st_nxt = (ib_r == cnt_r) ? ST_EX_A
                         : ((pop_count(sa_r) > pop_count(s_rd)) ? ST_EX_E : ST_EX_B);
      ST_EX_E: st_nxt = (e_r == EW'(ELEMENTS-1) && !diff[e_r]) ? ST_CLEAR
                         : (diff[e_r] ? ST_EX_C : ST_EX_E);
      ST_EX_C: st_nxt = t_rd ? ST_EX_B
                         : ((e_r == EW'(ELEMENTS-1)) ? ST_CLEAR : ST_EX_E);
      ST_CLEAR: if (clr_r[ELEMENTS]) st_nxt = boot_r ? ST_IDLE : ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt = cur_r; cnt_nxt = cnt_r; sa_nxt = sa_r; sb_nxt = sb_r; sub_nxt = sub_r;
    ia_nxt = ia_r; ib_nxt = ib_r; e_nxt = e_r; ok_nxt = ok_r; ph_nxt = 1'b0;
    clr_nxt = clr_r; ov_nxt = ov_r && !oacc; boot_nxt = boot_r;
    t_we = 1'b0; t_wa = cur_r; t_wd = 1'b1; t_ra = '0; s_we = 1'b0;
    s_ra = ia_r[SET_AW-1:0];
    unique case (st_r)
      ST_IDLE: if (acc) begin
        if (in_cmd == CMD_ADD && in_element >= 4'd1 && in_element <= 4'(ELEMENTS))
          cur_nxt = cur_r | (set_t'(1) << (in_element - 4'd1));
        else if (in_cmd == CMD_CLOSE) begin
          if (cnt_r < cnt_t'(MAX_SETS)) begin
            t_we = 1'b1; s_we = 1'b1; cnt_nxt = cnt_r + 1'b1;
          end
          cur_nxt = '0;
        end else if (in_cmd == CMD_EVAL) begin
          ok_nxt = 1'b1; ia_nxt = '0; clr_nxt = '0;
        end
      end
      ST_EMPTY: begin
        ph_nxt = 1'b1;
        if (ph_r && !t_rd) ok_nxt = 1'b0;
      end
      ST_HRD_A: begin
        ph_nxt = !ph_r;
        if (ph_r) begin sa_nxt = s_rd; sub_nxt = s_rd; end
      end
      ST_HRD_S: begin
        if (sub_r == '0) ia_nxt = (ia_r + 1'b1 == cnt_r) ? '0 : ia_r + 1'b1;
        sub_nxt = (sub_r - 1'b1) & sa_r;
        t_ra = (sub_r - 1'b1) & sa_r;
      end
      ST_HRD_C: if (!t_rd) ok_nxt = 1'b0;
      ST_EX_A: if (ia_r != cnt_r) begin
        ph_nxt = !ph_r;
        if (ph_r) begin sa_nxt = s_rd; ib_nxt = '0; end
      end
      ST_EX_B: begin
        s_ra = ib_r[SET_AW-1:0];
        ph_nxt = !ph_r;
        if (ph_r) begin
          sb_nxt = s_rd; e_nxt = '0; ib_nxt = ib_r + 1'b1;
          if (ib_r == cnt_r) begin ia_nxt = ia_r + 1'b1; ib_nxt = ib_r; end
        end
      end
      ST_EX_E: begin
        t_ra = sb_r | ebit;
        if (!diff[e_r]) begin
          if (e_r == EW'(ELEMENTS-1)) ok_nxt = 1'b0;
          else e_nxt = e_r + 1'b1;
        end
      end
      ST_EX_C: if (!t_rd) begin
        if (e_r == EW'(ELEMENTS-1)) ok_nxt = 1'b0;
        else e_nxt = e_r + 1'b1;
      end
      ST_CLEAR: begin
        t_we = !clr_r[ELEMENTS]; t_wa = clr_r[ELEMENTS-1:0]; t_wd = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r[ELEMENTS]) boot_nxt = 1'b0;
      end
      ST_DONE: begin
        ov_nxt = 1'b1; cnt_nxt = '0; cur_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; cur_r <= '0; cnt_r <= '0; clr_r <= '0; ov_r <= 1'b0;
      ph_r <= 1'b0; ok_r <= 1'b0; boot_r <= 1'b1;
    end else begin
      st_r <= st_nxt;
      cur_r <= cur_nxt; cnt_r <= cnt_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
      ph_r <= ph_nxt; ok_r <= ok_nxt; boot_r <= boot_nxt;
    end
    sa_r <= sa_nxt; sb_r <= sb_nxt; sub_r <= sub_nxt;
    ia_r <= ia_nxt; ib_r <= ib_nxt; e_r <= e_nxt;
  end

`ifndef ASSERT_OFF
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(MAX_SETS)) else $error("set count overflow");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) |=> out_valid) else $error("verdict lost");
`endif
endmodule

// File: dv/mac_checker.sv
`timescale 1ns / 1ps
// scoreboard for the matroid axiom checker: watches both channels, predicts verdicts
// from its own copy of the set family and compares them in order; uses mac_pkg
module mac_checker
  import mac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_element,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_is_matroid,
  output int         errors,
  output int         pending,
  output int         verdicts,
  output int         yes_count
);
  logic listed [TBL_DEPTH];
  set_t family [MAX_SETS];
  int   family_size;
  set_t cur_set;
  logic verdict_q [$];

  function automatic int ones(input set_t v);
    int n;
    n = 0;
    for (int i = 0; i < ELEMENTS; i++) n += v[i];
    return n;
  endfunction

  function automatic logic axioms_hold();
    set_t s, sub, sa, sb, diff;
    logic found;
    if (!listed[0]) return 1'b0;
    for (int a = 0; a < family_size; a++) begin
      s = family[a];
      sub = s;
      while (sub != '0) begin
        sub = (sub - 1'b1) & s;
        if (!listed[sub]) return 1'b0;
      end
    end
    for (int a = 0; a < family_size; a++) begin
      for (int b = 0; b < family_size; b++) begin
        sa = family[a];
        sb = family[b];
        if (ones(sa) <= ones(sb)) continue;
        diff = sa & ~sb;
        found = 1'b0;
        for (int e = 0; e < ELEMENTS; e++) begin
          if (diff[e] && listed[sb | (set_t'(1) << e)]) begin
            found = 1'b1;
            break;
          end
        end
        if (!found) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    verdicts = 0;
    yes_count = 0;
    family_size = 0;
    cur_set = '0;
    foreach (listed[i]) listed[i] = 1'b0;
  end

  always @(posedge clk) begin
    logic want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        case (in_cmd)
          CMD_ADD: begin
            if (in_element >= 4'd1 && in_element <= 4'(ELEMENTS))
              cur_set[in_element - 4'd1] = 1'b1;
          end
          CMD_CLOSE: begin
            if (family_size < MAX_SETS) begin
              family[family_size] = cur_set;
              listed[cur_set] = 1'b1;
              family_size++;
            end
            cur_set = '0;
          end
          CMD_EVAL: begin
            verdict_q = {verdict_q, axioms_hold()};
            foreach (listed[i]) listed[i] = 1'b0;
            family_size = 0;
            cur_set = '0;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual is_matroid=%0b",
                   $time, out_is_matroid);
        end else begin
          want = verdict_q.pop_front();
          verdicts++;
          if (out_is_matroid) yes_count++;
          if (out_is_matroid !== want) begin
            errors++;
            $display("%0t: is_matroid mismatch, expected %0b, actual %0b",
                     $time, want, out_is_matroid);
          end
        end
      end
      pending = verdict_q.size();
    end
  end
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// testbench top for matroid_axiom_checker_top: directed and random command streams
// with idle and stall phases; depends on mac_pkg, the block and mac_checker
module tb;
  import mac_pkg::*;

  localparam int LIMIT = 20000000;
  localparam int DRAIN = 4000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_cmd;
  logic [3:0] in_element;
  logic       out_valid;
  logic       out_stall;
  logic       out_is_matroid;
  int         errors, pending, verdicts, yes_count;
  int         idle_pct, stall_pct, sent, families, hold_cnt;
  logic       hold_req;
  longint     cycles;

  matroid_axiom_checker_top u_dut (.*);

  mac_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_element,
    .out_valid, .out_stall, .out_is_matroid,
    .errors, .pending, .verdicts, .yes_count
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver side, with an optional long hold-off
  initial begin
    out_stall = 1'b0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic put(input logic [1:0] c, input logic [3:0] e);
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_cmd = c;
    in_element = e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    sent++;
  endtask

  task automatic put_set(input set_t s);
    for (int i = 0; i < ELEMENTS; i++)
      if (s[i]) put(CMD_ADD, 4'(i + 1));
    put(CMD_CLOSE, 4'd0);
  endtask

  // mostly uniform matroids on a few elements, sometimes damaged, plus noise words
  task automatic put_family();
    set_t g, s;
    int k, r;
    g = '0;
    k = $urandom_range(0, 4);
    for (int i = 0; i < k; i++) g[$urandom_range(0, ELEMENTS - 1)] = 1'b1;
    r = $urandom_range(0, 4);
    for (int m = 0; m < TBL_DEPTH; m++) begin
      s = set_t'(m);
      if ((s & ~g) != '0) continue;
      if (u_chk.ones(s) > r) continue;
      if ($urandom_range(0, 99) < 6) continue;
      if ($urandom_range(0, 99) < 5) put(CMD_ADD, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 99) < 5) put(CMD_RSVD, 4'($urandom));
      put_set(s);
      if ($urandom_range(0, 99) < 5) put_set(s);
    end
    if ($urandom_range(0, 99) < 15) put_set(set_t'($urandom_range(0, TBL_DEPTH - 1)));
    if ($urandom_range(0, 99) < 10) put(CMD_ADD, 4'($urandom_range(1, ELEMENTS)));
    put(CMD_EVAL, 4'($urandom));
    families++;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_ADD;
    in_element = '0;
    hold_req = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    families = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty family, then only the empty set
    put(CMD_EVAL, 4'd0);
    put(CMD_CLOSE, 4'd0);
    put(CMD_EVAL, 4'd15);
    // repeated and out-of-range elements, unused command, empty close
    put(CMD_ADD, 4'd1);
    put(CMD_ADD, 4'd1);
    put(CMD_ADD, 4'd0);
    put(CMD_ADD, 4'd11);
    put(CMD_ADD, 4'd15);
    put(CMD_RSVD, 4'd6);
    put(CMD_CLOSE, 4'd0);
    put(CMD_CLOSE, 4'd0);
    put(CMD_EVAL, 4'd0);
    // missing subsets
    put(CMD_ADD, 4'd10);
    put(CMD_ADD, 4'd2);
    put(CMD_CLOSE, 4'd0);
    put(CMD_CLOSE, 4'd0);
    put(CMD_EVAL, 4'd0);
    // unclosed set at evaluate
    put(CMD_ADD, 4'd3);
    put(CMD_EVAL, 4'd0);
    // exchange fails
    put_set('0);
    put_set(set_t'(1));
    put_set(set_t'(2));
    put_set(set_t'(4));
    put_set(set_t'(3));
    put(CMD_EVAL, 4'd0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? 73 : (ph == 3 ? 10 : 0);
      stall_pct = (ph == 2) ? 73 : 0;
      if (ph == 3) begin
        idle_pct = 10;
        stall_pct = 10;
      end
      if (ph == 0) hold_req = 1'b1;
      if (ph == 2) begin
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(negedge clk);
      end
      for (int n = sent + 140; sent < n; ) put_family();
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d words in %0d random families", sent, families);
    $display("checked %0d verdicts, %0d of them true", verdicts, yes_count);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
